/* rtl/lpg_pkg.sv */
`timescale 1ns / 1ps

package lpg_pkg;

    typedef enum logic {
        MODE_LOAD = 1'b0,
        MODE_STEP = 1'b1
    } t_mode;

endpackage

/* rtl/lpg_cmd_if.sv */
`timescale 1ns / 1ps

interface lpg_cmd_if #(
    parameter int COORD_BITS = 12
);
    logic                         valid;
    logic                         ready;
    lpg_pkg::t_mode               mode;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;

    modport source (output valid, mode, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, mode, start_x, start_y, end_x, end_y, output ready);
endinterface

/* rtl/lpg_pix_if.sv */
`timescale 1ns / 1ps

interface lpg_pix_if #(
    parameter int COORD_BITS = 12
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic                         last_pixel;

    modport source (output valid, pixel_x, pixel_y, last_pixel, input ready);
    modport sink   (input valid, pixel_x, pixel_y, last_pixel, output ready);
endinterface

/* rtl/line_pixel_generator.sv */
`timescale 1ns / 1ps

// Channel  Direction  Word
// i_cmd    in         mode, start_x, start_y, end_x, end_y (load or step)
// o_pix    out        pixel_x, pixel_y, last_pixel
//
// One word per clock each way unless o_pix stalls; a step word reaches o_pix
// through the command register, then the pixel register.
// A load word or a step with no active line is consumed and emits nothing.
// Reset clears the line state; no line is active afterwards.
// A stalled o_pix holds the command register and then i_cmd.ready, except
// that loads and idle steps still drain.
module line_pixel_generator #(
    parameter int COORD_BITS = 12
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lpg_cmd_if.sink    i_cmd,
    lpg_pix_if.source  o_pix
);
    import lpg_pkg::*;

    localparam int EW = COORD_BITS + 3;
    localparam int DW = COORD_BITS + 1;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [EW-1:0]         t_err;
    typedef logic signed [DW-1:0]         t_diff;

    logic   r_in_valid;
    t_mode  r_in_mode;
    t_coord r_in_sx;
    t_coord r_in_sy;
    t_coord r_in_ex;
    t_coord r_in_ey;

    t_coord r_cur_x;
    t_coord r_cur_y;
    t_coord r_major_end;
    t_err   r_err;
    t_err   r_inc_str;
    t_err   r_inc_diag;
    logic   r_minor_neg;
    logic   r_y_major;
    logic   r_active;

    logic   r_out_valid;
    t_coord r_pix_x;
    t_coord r_pix_y;
    logic   r_pix_last;

    logic   out_free;
    logic   proc_fire;
    logic   emit;
    logic   is_load;

    t_diff  dx;
    t_diff  dy;
    t_diff  neg_dx;
    t_diff  neg_dy;
    logic [COORD_BITS-1:0] adx;
    logic [COORD_BITS-1:0] ady;
    logic   ld_y_major;
    t_diff  dm;
    t_diff  dn;
    logic   ld_swap;
    logic   ld_minor_neg;
    logic [COORD_BITS-1:0] dmaj;
    logic [COORD_BITS-1:0] dmin;
    t_err   ld_inc_str;
    t_err   ld_inc_diag;
    t_err   ld_err;
    t_coord ld_cur_x;
    t_coord ld_cur_y;
    t_coord ld_major_end;

    t_coord maj;
    t_coord mnr;
    logic   last;
    logic   go_diag;
    t_coord n_maj;
    t_coord n_mnr;
    t_err   n_err;

    always_comb begin
        unique case (r_in_mode)
            MODE_LOAD: is_load = 1'b1;
            MODE_STEP: is_load = 1'b0;
            default:   is_load = 1'b0;
        endcase
    end

    assign out_free    = !r_out_valid || o_pix.ready;
    assign proc_fire   = r_in_valid && (is_load || !r_active || out_free);
    assign emit        = r_in_valid && !is_load && r_active && out_free;
    assign i_cmd.ready = !r_in_valid || proc_fire;

    // Load setup
    assign dx     = t_diff'({r_in_ex[COORD_BITS-1], r_in_ex})
                  - t_diff'({r_in_sx[COORD_BITS-1], r_in_sx});
    assign dy     = t_diff'({r_in_ey[COORD_BITS-1], r_in_ey})
                  - t_diff'({r_in_sy[COORD_BITS-1], r_in_sy});
    assign neg_dx = -dx;
    assign neg_dy = -dy;
    assign adx    = dx[DW-1] ? neg_dx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
    assign ady    = dy[DW-1] ? neg_dy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];

    assign ld_y_major   = ady > adx;
    assign dm           = ld_y_major ? dy : dx;
    assign dn           = ld_y_major ? dx : dy;
    assign ld_swap      = dm[DW-1];
    assign ld_minor_neg = (dn != '0) && (dn[DW-1] != ld_swap);
    assign dmaj         = ld_y_major ? ady : adx;
    assign dmin         = ld_y_major ? adx : ady;

    assign ld_inc_str   = t_err'({2'b00, dmin, 1'b0});
    assign ld_inc_diag  = ld_inc_str - t_err'({2'b00, dmaj, 1'b0});
    assign ld_err       = ld_inc_str - t_err'({3'b000, dmaj});
    assign ld_cur_x     = ld_swap ? r_in_ex : r_in_sx;
    assign ld_cur_y     = ld_swap ? r_in_ey : r_in_sy;
    assign ld_major_end = ld_y_major ? (ld_swap ? r_in_sy : r_in_ey)
                                     : (ld_swap ? r_in_sx : r_in_ex);

    // Step
    assign maj     = r_y_major ? r_cur_y : r_cur_x;
    assign mnr     = r_y_major ? r_cur_x : r_cur_y;
    assign last    = maj >= r_major_end;
    assign go_diag = r_err > t_err'(0);
    assign n_maj   = maj + t_coord'(1);
    assign n_mnr   = !go_diag ? mnr : (r_minor_neg ? mnr - t_coord'(1) : mnr + t_coord'(1));
    assign n_err   = r_err + (go_diag ? r_inc_diag : r_inc_str);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_in_valid <= i_cmd.valid;
        end
        if (i_cmd.ready && i_cmd.valid) begin
            r_in_mode <= i_cmd.mode;
            r_in_sx   <= i_cmd.start_x;
            r_in_sy   <= i_cmd.start_y;
            r_in_ex   <= i_cmd.end_x;
            r_in_ey   <= i_cmd.end_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_major_end <= '0;
            r_err       <= '0;
            r_inc_str   <= '0;
            r_inc_diag  <= '0;
            r_minor_neg <= 1'b0;
            r_y_major   <= 1'b0;
            r_active    <= 1'b0;
        end else if (proc_fire && is_load) begin
            r_cur_x     <= ld_cur_x;
            r_cur_y     <= ld_cur_y;
            r_major_end <= ld_major_end;
            r_err       <= ld_err;
            r_inc_str   <= ld_inc_str;
            r_inc_diag  <= ld_inc_diag;
            r_minor_neg <= ld_minor_neg;
            r_y_major   <= ld_y_major;
            r_active    <= 1'b1;
        end else if (emit) begin
            if (last) begin
                r_active <= 1'b0;
            end else begin
                r_err <= n_err;
                if (r_y_major) begin
                    r_cur_y <= n_maj;
                    r_cur_x <= n_mnr;
                end else begin
                    r_cur_x <= n_maj;
                    r_cur_y <= n_mnr;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= emit;
        end
        if (emit) begin
            r_pix_x    <= r_cur_x;
            r_pix_y    <= r_cur_y;
            r_pix_last <= last;
        end
    end

    assign o_pix.valid      = r_out_valid;
    assign o_pix.pixel_x    = r_pix_x;
    assign o_pix.pixel_y    = r_pix_y;
    assign o_pix.last_pixel = r_pix_last;

    a_last_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit && last |=> !r_active && r_out_valid && r_pix_last)
        else $error("line still active after last pixel");

    a_load_starts_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc_fire && is_load |=> r_active)
        else $error("load did not start a line");

    a_idle_step_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !is_load && !r_active && out_free |=> !r_out_valid)
        else $error("step with no line produced a pixel");

    a_pixel_from_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> r_pix_x == $past(r_cur_x) && r_pix_y == $past(r_cur_y))
        else $error("pixel does not match cursor");

endmodule
